@@ rtl/adamax_optimizer_update_assert.svh @@
// assertion macros for the adamax update block
`ifndef ADAMAX_OPTIMIZER_UPDATE_ASSERT_SVH
`define ADAMAX_OPTIMIZER_UPDATE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define AMX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define AMX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/amx_pkg.sv @@
// shared constants for the adamax update block
`default_nettype none
package amx_pkg;
    localparam int MEM_DEPTH_DEF = 4096;
    localparam int VAL_W_DEF     = 32;
    localparam int IDX_W         = 12;
    localparam int BETA_W        = 16;
    localparam int SCALE_W       = 32;
    localparam int CFG_IDX_W     = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;
    localparam logic [BETA_W-1:0]  BETA1_RST = 16'd58982;
    localparam logic [BETA_W-1:0]  BETA2_RST = 16'd65470;
    localparam logic [SCALE_W-1:0] SCALE_RST = 32'd33554;
    // front-to-back queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
endpackage
`default_nettype wire

@@ rtl/adamax_optimizer_update.sv @@
// AdaMax update engine, one element per cycle while the output is not stalled. The moment
// update is pipelined, and the scaled quotient uses a pipelined restoring divider of 65
// stages, one quotient bit per stage; one item is accepted every cycle unless stalled.
// A short queue parts the moment front from the divider. After reset a clearing pass
// over all MEMORY_DEPTH entries zeroes both moment stores, during which no item is taken.
`default_nettype none
`include "adamax_optimizer_update_assert.svh"
module adamax_optimizer_update
    import amx_pkg::*;
#(
    parameter int MEMORY_DEPTH = MEM_DEPTH_DEF,
    parameter int VALUE_WIDTH  = VAL_W_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // element_index [11:0], gradient [VALUE_WIDTH+11:12], zero fill
    input  wire logic [((IDX_W+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // update_value [VALUE_WIDTH-1:0]
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // saturated
    output logic                          m_axis_tuser,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [SCALE_W-1:0]       i_cfg_data
);
    localparam int NW = SCALE_W + VALUE_WIDTH;
    localparam int DW = VALUE_WIDTH + 8;
    localparam int OUT_W = ((VALUE_WIDTH+7)/8)*8;
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [BETA_W-1:0]  r_beta1, r_beta2;
    logic [SCALE_W-1:0] r_scale;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta1 <= BETA1_RST;
            r_beta2 <= BETA2_RST;
            r_scale <= SCALE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BETA1: r_beta1 <= i_cfg_data[BETA_W-1:0];
                REG_BETA2: r_beta2 <= i_cfg_data[BETA_W-1:0];
                REG_SCALE: r_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic          f_valid, f_ready, q_valid, q_ready;
    logic [NW-1:0] f_num, q_num;
    logic [DW-1:0] f_den, q_den;
    logic          f_neg, q_neg;

    amx_front #(.MEM_DEPTH(MEMORY_DEPTH), .VAL_W(VALUE_WIDTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_index(s_axis_tdata[IDX_W-1:0]),
        .i_grad(s_axis_tdata[IDX_W+VALUE_WIDTH-1:IDX_W]),
        .i_beta1(r_beta1), .i_beta2(r_beta2), .i_scale(r_scale),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_num(f_num), .o_den(f_den), .o_neg(f_neg)
    );

    amx_queue #(.W(NW+DW+1)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data({f_neg, f_den, f_num}),
        .o_valid(q_valid), .i_ready(q_ready), .o_data({q_neg, q_den, q_num})
    );

    logic [VALUE_WIDTH-1:0] val;
    amx_back #(.VAL_W(VALUE_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready),
        .i_num(q_num), .i_den(q_den), .i_neg(q_neg),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(val), .o_sat(m_axis_tuser)
    );
    assign m_axis_tdata = OUT_W'(val);

    // result item held steady while the receiver stalls, clamp only at the limits
    `AMX_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result item dropped while stalled")
    `AMX_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result item changed while stalled")
    `AMX_ASSERT_IMP(a_sat_clamp, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, (val == VAL_MAX) || (val == VAL_MIN), "saturated item not at a range limit")
endmodule
`default_nettype wire

@@ rtl/amx_front.sv @@
// front part: moment stores, moment update and divide operands
`default_nettype none
module amx_front
    import amx_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF,
    parameter int VAL_W     = VAL_W_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [IDX_W-1:0]     i_index,
    input  wire logic [VAL_W-1:0]     i_grad,
    input  wire logic [BETA_W-1:0]    i_beta1,
    input  wire logic [BETA_W-1:0]    i_beta2,
    input  wire logic [SCALE_W-1:0]   i_scale,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [SCALE_W+VAL_W-1:0]  o_num,
    output logic [VAL_W+7:0]          o_den,
    output logic                      o_neg
);
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int MW = VAL_W + BETA_W + 2;
    localparam int NW = SCALE_W + VAL_W;
    localparam int DW = VAL_W + 8;
    // reciprocal of the depth, exact for every index value
    localparam int RS = IDX_W + AW;
    localparam longint unsigned RM =
        ((64'd1 << RS) + longint'(MEM_DEPTH) - 64'd1) / longint'(MEM_DEPTH);

    // clearing pass after reset
    logic [AW:0] r_clr, n_clr;
    logic        clearing;
    assign clearing = (r_clr < (AW+1)'(MEM_DEPTH));

    logic [VAL_W-1:0] r_m_mem [MEM_DEPTH];
    logic [VAL_W-1:0] r_v_mem [MEM_DEPTH];

    // pipeline: s1 read, s2 moment calc, s3 operands; s3 output register
    logic              r_v1, r_v2, r_v3;
    logic [AW-1:0]     r_a1, r_a2;
    logic [VAL_W-1:0]  r_g1;
    logic [VAL_W-1:0]  r_mr, r_vr;
    logic [VAL_W-1:0]  r_mn, r_vn;
    logic [NW-1:0]     r_num;
    logic [DW-1:0]     r_den;
    logic              r_neg;
    logic              adv;

    // whole pipeline moves as one; stalls when output held
    assign adv     = !r_v3 || i_ready;
    assign o_ready = adv && !clearing;
    assign o_valid = r_v3;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_neg   = r_neg;

    // address wrap modulo the depth by reciprocal multiplication
    logic [2*IDX_W:0] iq_prod;
    logic [IDX_W-1:0] iq, irem;
    logic [AW-1:0]    wa;
    assign iq_prod = i_index * RM[IDX_W:0];
    assign iq      = IDX_W'(iq_prod >> RS);
    assign irem    = i_index - IDX_W'(32'(iq) * 32'(MEM_DEPTH));
    assign wa      = AW'(irem);

    // moment arithmetic on stage 2 inputs (read data plus bypass)
    logic [VAL_W-1:0] m_src, v_src;
    logic             byp;
    logic signed [MW-1:0] x;
    logic [MW-1:0]        xn;
    logic [VAL_W-1:0]     m_new;
    logic [VAL_W+BETA_W:0] dv;
    logic [VAL_W:0]       d;
    logic [VAL_W-1:0]     dsat, absg, v_new;
    always_comb begin
        byp   = r_v2 && (r_a2 == r_a1);
        m_src = byp ? r_mn : r_mr;
        v_src = byp ? r_vn : r_vr;
        x = MW'($signed(m_src)) * $signed({2'b0, i_beta1})
          + MW'($signed(r_g1)) * $signed(MW'(17'h10000 - {1'b0, i_beta1}));
        xn = MW'(x + MW'(32768));
        m_new = VAL_W'(xn >>> 16);
        dv = (VAL_W+BETA_W+1)'(v_src) * i_beta2 + (VAL_W+BETA_W+1)'(32768);
        d  = (VAL_W+1)'(dv >> 16) + (VAL_W+1)'(1);
        dsat = d[VAL_W] ? '1 : d[VAL_W-1:0];
        absg = r_g1[VAL_W-1] ? VAL_W'(-r_g1) : r_g1;
        v_new = (absg > dsat) ? absg : dsat;
    end

    logic [VAL_W-1:0] absm;
    assign absm = r_mn[VAL_W-1] ? VAL_W'(-r_mn) : r_mn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_clr <= n_clr;
            if (adv) begin
                r_v1 <= i_valid && o_ready;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end
    assign n_clr = clearing ? r_clr + 1'b1 : r_clr;

    // memories: read at stage 0, write back at stage 1 result
    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_m_mem[r_clr[AW-1:0]] <= '0;
            r_v_mem[r_clr[AW-1:0]] <= '0;
        end else if (adv && r_v1) begin
            r_m_mem[r_a1] <= m_new;
            r_v_mem[r_a1] <= v_new;
        end
        if (adv) begin
            if (r_v1 && r_a1 == wa) begin
                r_mr <= m_new;
                r_vr <= v_new;
            end else begin
                r_mr <= r_m_mem[wa];
                r_vr <= r_v_mem[wa];
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a1  <= wa;
            r_g1  <= i_grad;
            r_a2  <= r_a1;
            r_mn  <= m_new;
            r_vn  <= v_new;
            r_num <= NW'(i_scale) * NW'(absm);
            r_den <= {r_vn, 8'd0};
            r_neg <= r_mn[VAL_W-1];
        end
    end
endmodule
`default_nettype wire

@@ rtl/amx_queue.sv @@
// short queue between front and back
`default_nettype none
module amx_queue
    import amx_pkg::*;
#(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);
    logic [W-1:0]  r_mem [Q_DEPTH];
    logic [Q_AW:0] r_cnt;
    logic [Q_AW-1:0] r_wp, r_rp;
    logic wr, rd;
    assign o_ready = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_AW+1)'(wr) - (Q_AW+1)'(rd);
        end
    end
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

@@ rtl/amx_back.sv @@
// back part: pipelined restoring divider, rounding, sign and clamp
`default_nettype none
module amx_back
    import amx_pkg::*;
#(
    parameter int VAL_W = VAL_W_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [SCALE_W+VAL_W-1:0] i_num,
    input  wire logic [VAL_W+7:0]        i_den,
    input  wire logic                    i_neg,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [VAL_W-1:0]             o_value,
    output logic                         o_sat
);
    localparam int NW = SCALE_W + VAL_W + 1;
    localparam int DW = VAL_W + 8;
    localparam int ST = NW;   // one quotient bit per stage

    logic          r_v   [ST+1];
    logic [NW-1:0] r_q   [ST+1];
    logic [DW:0]   r_r   [ST+1];
    logic [DW-1:0] r_d   [ST+1];
    logic          r_n   [ST+1];
    logic          adv;
    logic          r_ov;
    logic [VAL_W-1:0] r_val;
    logic          r_sat;

    assign adv = !r_ov || i_ready;
    assign o_ready = adv;
    assign o_valid = r_ov;
    assign o_value = r_val;
    assign o_sat = r_sat;

    // stage 0: add half the divisor for rounding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (adv) r_v[0] <= i_valid;
        if (adv) begin
            r_q[0] <= NW'(i_num) + NW'(i_den >> 1);
            r_r[0] <= '0;
            r_d[0] <= i_den;
            r_n[0] <= i_neg;
        end
    end

    // divider stages, msb first
    for (genvar s = 0; s < ST; s++) begin : g_div
        logic [DW+1:0] t;
        logic [DW:0]   rem;
        logic          qb;
        always_comb begin
            t   = {r_r[s], r_q[s][NW-1]} - {2'b0, r_d[s]};
            qb  = !t[DW+1];
            rem = qb ? t[DW:0] : {r_r[s][DW-1:0], r_q[s][NW-1]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[s+1] <= 1'b0;
            else if (adv) r_v[s+1] <= r_v[s];
            if (adv) begin
                r_q[s+1] <= {r_q[s][NW-2:0], qb};
                r_r[s+1] <= rem;
                r_d[s+1] <= r_d[s];
                r_n[s+1] <= r_n[s];
            end
        end
    end

    // sign and clamp
    logic [NW-1:0] mag;
    logic [VAL_W-1:0] val;
    logic sat;
    always_comb begin
        mag = r_q[ST];
        if (r_n[ST]) begin
            sat = mag > (NW'(1) << (VAL_W-1));
            val = sat ? {1'b1, {(VAL_W-1){1'b0}}} : VAL_W'(-mag);
        end else begin
            sat = mag > ((NW'(1) << (VAL_W-1)) - NW'(1));
            val = sat ? {1'b0, {(VAL_W-1){1'b1}}} : VAL_W'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_v[ST];
        if (adv) begin
            r_val <= val;
            r_sat <= sat;
        end
    end
endmodule
`default_nettype wire
